[design/fcv_pkg.sv]
// Package for the fixed-point to single-precision converter.
// Holds the stage payload types, format constants and the leading-one search.
// No dependencies.
package fcv_pkg;

  localparam int unsigned XW = 32;  // integer input width
  localparam int unsigned EW = 16;  // exponent input width
  localparam int unsigned MW = 23;  // mantissa field width
  localparam int unsigned BW = 18;  // working width of the biased exponent

  localparam logic signed [BW-1:0] EXP_BIAS  = 18'sd127;
  localparam logic signed [BW-1:0] EXP_MAX   = 18'sd254;
  localparam logic signed [BW-1:0] EXP_MIN   = -18'sd22;
  localparam logic signed [BW-1:0] MANT_BITS = 18'sd23;
  localparam logic [31:0]          FLOAT_INF = 32'h7F80_0000;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_INF,
    KIND_NUM
  } kind_t;

  // after the leading-one search
  typedef struct packed {
    logic [XW-1:0]        x;
    logic signed [EW-1:0] exp_in;
    logic [4:0]           msb;
    logic                 zero;
  } lead_t;

  // after exponent forming and classification
  typedef struct packed {
    logic [XW-1:0]    frac;
    logic signed [6:0] sh;    // right shift of frac, negative means left
    logic [7:0]       e8;
    kind_t            kind;
  } align_t;

  function automatic logic [4:0] msb_of(input logic [XW-1:0] x);
    logic [4:0] pos;
    pos = 5'd0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) pos = 5'(i);
    end
    return pos;
  endfunction

endpackage

[design/fcv_lead.sv]
// First stage: registers the input word and finds its leading one.
// Depends on fcv_pkg.
module fcv_lead import fcv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [XW-1:0]        x,
  input  logic signed [EW-1:0] exp_in,
  output logic                 valid,
  output lead_t                data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      data.x      <= x;
      data.exp_in <= exp_in;
      data.msb    <= msb_of(x);
      data.zero   <= (x == '0);
    end
  end

endmodule

[design/fcv_align.sv]
// Second stage: forms the biased exponent, classifies the word and works out
// the mantissa shift. Depends on fcv_pkg.
module fcv_align import fcv_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  logic   in_valid,
  input  lead_t  in_data,
  output logic   valid,
  output align_t data
);

  logic signed [BW-1:0] e;
  logic signed [BW-1:0] msb_s;
  logic signed [BW-1:0] cnt;
  logic signed [BW-1:0] sh_full;
  align_t               data_next;

  always_comb begin
    msb_s = $signed({13'd0, in_data.msb});
    e     = msb_s - $signed({{(BW-EW){in_data.exp_in[EW-1]}}, in_data.exp_in}) + EXP_BIAS;
    data_next = '0;
    if (e <= 18'sd0) begin
      // denormal: keep the leading one, step of 2^-149
      cnt            = msb_s + 18'sd1 - e;
      data_next.frac = in_data.x;
      data_next.e8   = 8'd0;
    end else begin
      cnt            = msb_s;
      data_next.frac = in_data.x ^ (32'd1 << in_data.msb);
      data_next.e8   = e[7:0];
    end
    sh_full      = cnt - MANT_BITS;
    data_next.sh = sh_full[6:0];
    if (in_data.zero || e < EXP_MIN) begin
      data_next.kind = KIND_ZERO;
    end else if (e > EXP_MAX) begin
      data_next.kind = KIND_INF;
    end else begin
      data_next.kind = KIND_NUM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      data <= data_next;
    end
  end

endmodule

[design/fcv_round.sv]
// Third stage: aligns the mantissa, adds the first dropped bit and selects
// the special results. Depends on fcv_pkg.
module fcv_round import fcv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  align_t      in_data,
  output logic        valid,
  output logic [31:0] bits,
  output kind_t       kind
);

  logic [XW-1:0] shifted;
  logic [4:0]    amt;
  logic [4:0]    ridx;
  logic          rbit;
  logic [31:0]   res;

  always_comb begin
    ridx = in_data.sh[4:0] - 5'd1;
    if (!in_data.sh[6]) begin
      amt     = in_data.sh[4:0];
      shifted = in_data.frac >> amt;
      rbit    = (in_data.sh != 7'sd0) ? in_data.frac[ridx] : 1'b0;
    end else begin
      amt     = 5'(-in_data.sh);
      shifted = in_data.frac << amt;
      rbit    = 1'b0;
    end
    // carry out of the mantissa ripples into the exponent
    res = {1'b0, in_data.e8, shifted[MW-1:0]} + {31'd0, rbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      kind <= in_data.kind;
      unique case (in_data.kind)
        KIND_ZERO: bits <= 32'd0;
        KIND_INF:  bits <= FLOAT_INF;
        KIND_NUM:  bits <= res;
        default:   bits <= 32'd0;
      endcase
    end
  end

endmodule

[design/fixed_to_float32_convert.sv]
// Top level of the unsigned fixed-point to single-precision converter.
// Depends on fcv_pkg, fcv_lead, fcv_align and fcv_round.
//
// A word on the input channel is fixed_integer * 2^-fixed_exponent; it is
// taken when fixed_valid is high and fixed_stall low. Each word gives one
// word on the output channel, float_bits, taken when float_valid is high
// and float_stall low. The sign bit is always zero; overflow gives
// +infinity, values below the smallest denormal give zero, and rounding
// adds the first dropped bit.
//
// Three register stages: leading-one search, exponent and shift forming,
// then mantissa shift with rounding. One word is taken every cycle while
// the output is not stalled. A stall on the output holds the last stage;
// earlier stages keep moving until they meet a full stage, so bubbles are
// squeezed out and fixed_stall rises only when all three stages hold words.
// Synchronous reset empties the pipeline; no word is held across it.
module fixed_to_float32_convert import fcv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fixed_valid,
  output logic                 fixed_stall,
  input  logic [XW-1:0]        fixed_integer,
  input  logic signed [EW-1:0] fixed_exponent,
  output logic                 float_valid,
  input  logic                 float_stall,
  output logic [31:0]          float_bits
);

  logic   v1, v2, v3;
  logic   adv1, adv2, adv3;
  lead_t  s1;
  align_t s2;
  kind_t  k3;

  // a stage moves when it is empty or the one after it moves
  assign adv3        = !v3 || !float_stall;
  assign adv2        = !v2 || adv3;
  assign adv1        = !v1 || adv2;
  assign fixed_stall = !adv1;
  assign float_valid = v3;

  fcv_lead u_lead (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv1),
    .in_valid (fixed_valid),
    .x        (fixed_integer),
    .exp_in   (fixed_exponent),
    .valid    (v1),
    .data     (s1)
  );

  fcv_align u_align (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv2),
    .in_valid (v1),
    .in_data  (s1),
    .valid    (v2),
    .data     (s2)
  );

  fcv_round u_round (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv3),
    .in_valid (v2),
    .in_data  (s2),
    .valid    (v3),
    .bits     (float_bits),
    .kind     (k3)
  );

  a_take_lands: assert property (@(posedge clk) disable iff (rst)
    fixed_valid && !fixed_stall |=> v1)
    else $error("accepted word did not reach the first stage");

  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    v1 && v2 && v3 && float_stall |-> fixed_stall)
    else $error("input taken while the pipeline is full and stalled");

  a_sign_zero: assert property (@(posedge clk) disable iff (rst)
    float_valid |-> !float_bits[31])
    else $error("sign bit set on output word");

  a_special: assert property (@(posedge clk) disable iff (rst)
    float_valid && k3 == KIND_INF |-> float_bits == FLOAT_INF)
    else $error("overflow word is not infinity");

endmodule
